FILE: rtl/u8u16_pkg.sv
// u8u16_pkg: shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8u16_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned UNIT_W  = 16;
	localparam int unsigned COUNT_W = 10;

	localparam logic [COUNT_W-1:0] MAX_UNITS_RST = 10'd256;

	// lead byte classes
	localparam logic [7:0] ASCII_MASK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD_DATA  = 8'h1F;
	localparam logic [7:0] CONT_DATA  = 8'h3F;

	localparam logic [UNIT_W-1:0] REPLACEMENT = 16'h003F; // '?'

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	typedef struct packed {
		logic [UNIT_W-1:0]  code_unit;
		logic               string_end;
		logic [COUNT_W-1:0] unit_count;
	} unit_t;

endpackage

`default_nettype wire

FILE: rtl/u8u16_if.sv
// u8u16_byte_if / u8u16_unit_if: valid/ready channels for input bytes and
// decoded code units. Depends on u8u16_pkg.
`default_nettype none

interface u8u16_byte_if;
	logic                          valid;
	logic                          ready;
	logic [u8u16_pkg::BYTE_W-1:0]  in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8u16_unit_if;
	logic                          valid;
	logic                          ready;
	logic [u8u16_pkg::UNIT_W-1:0]  code_unit;
	logic                          string_end;
	logic [u8u16_pkg::COUNT_W-1:0] unit_count;

	modport source (output valid, output code_unit, output string_end,
		output unit_count, input ready);
	modport sink   (input valid, input code_unit, input string_end,
		input unit_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/u8u16_core.sv
// u8u16_core: decode state (accumulator, pending count, unit count, discard
// flag) and the per-byte step; also holds the max_units register.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [u8u16_pkg::COUNT_W-1:0] cfg_wdata,
	input  wire logic                         take,
	input  wire logic [u8u16_pkg::BYTE_W-1:0]  byte_in,
	output      logic                         res_valid,
	output      u8u16_pkg::unit_t             res
);
	import u8u16_pkg::*;

	logic [COUNT_W-1:0] max_q;
	logic [UNIT_W-1:0]  acc_q, acc_n;
	logic [1:0]         pend_q, pend_n;
	logic [COUNT_W-1:0] count_q, count_n;
	logic               discard_q, discard_n;
	logic               emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_UNITS_RST;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_comb begin
		acc_n     = acc_q;
		pend_n    = pend_q;
		count_n   = count_q;
		discard_n = discard_q;
		emit      = 1'b0;
		res       = '0;
		if (byte_in == '0) begin
			// terminator; suppressed when the end marker has already gone out
			emit           = !discard_q;
			res.string_end = 1'b1;
			res.unit_count = count_q;
			acc_n          = '0;
			pend_n         = PEND_NONE;
			count_n        = '0;
			discard_n      = 1'b0;
		end else if (discard_q) begin
			emit = 1'b0;
		end else if (pend_q != PEND_NONE) begin
			acc_n  = {acc_q[UNIT_W-7:0], byte_in[5:0] & CONT_DATA[5:0]};
			pend_n = pend_q - 2'd1;
			if (pend_q == PEND_ONE) begin
				emit           = 1'b1;
				count_n        = count_q + 1'b1;
				res.code_unit  = acc_n;
				res.unit_count = count_n;
			end
		end else if (count_q >= max_q) begin
			// limit reached: close the string early, drop until terminator
			emit           = 1'b1;
			res.string_end = 1'b1;
			res.unit_count = count_q;
			acc_n          = '0;
			discard_n      = 1'b1;
		end else if ((byte_in & ASCII_MASK) == '0) begin
			emit           = 1'b1;
			count_n        = count_q + 1'b1;
			res.code_unit  = {{(UNIT_W-BYTE_W){1'b0}}, byte_in};
			res.unit_count = count_n;
		end else if ((byte_in & LEAD2_MASK) == LEAD2_CODE) begin
			acc_n  = {{(UNIT_W-BYTE_W){1'b0}}, byte_in & LEAD_DATA};
			pend_n = PEND_ONE;
		end else if ((byte_in & LEAD3_MASK) == LEAD3_CODE) begin
			acc_n  = {{(UNIT_W-BYTE_W){1'b0}}, byte_in & LEAD_DATA};
			pend_n = PEND_TWO;
		end else begin
			emit           = 1'b1;
			count_n        = count_q + 1'b1;
			res.code_unit  = REPLACEMENT;
			res.unit_count = count_n;
		end
	end

	assign res_valid = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			pend_q    <= PEND_NONE;
			count_q   <= '0;
			discard_q <= 1'b0;
		end else if (take) begin
			acc_q     <= acc_n;
			pend_q    <= pend_n;
			count_q   <= count_n;
			discard_q <= discard_n;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/u8u16_outbuf.sv
// u8u16_outbuf: result register plus one skid entry; ready upstream is a
// register, so the receiver's ready never reaches the input side.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_outbuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  u8u16_pkg::unit_t      push_data,
	output      logic             can_take,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      u8u16_pkg::unit_t out_data
);
	import u8u16_pkg::*;

	logic  main_v_q, skid_v_q;
	unit_t main_q, skid_q;
	logic  pop;

	assign pop       = main_v_q && out_ready;
	assign can_take  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/utf8_to_utf16_decoder.sv
// utf8_to_utf16_decoder: top level of the UTF-8 to UTF-16 (BMP) decoder.
// Depends on u8u16_pkg, u8u16_if, u8u16_core and u8u16_outbuf.
//
// Usage:
//   bytes  - valid/ready request channel, one UTF-8 byte per request; a
//            zero byte terminates the string.
//   units  - valid/ready request channel of results: a code unit with its
//            running count, or an end marker (string_end = 1, code_unit 0)
//            carrying the string's unit count.
//   max_units_we / max_units_wdata - write of the per-string unit limit;
//            write only while the block is idle.
//   Throughput is one byte per cycle while bytes.ready is high. A result is
//   registered in the result register after the decode step, or in the skid
//   entry when the receiver stalls. Lead bytes of multi-byte sequences and
//   bytes dropped after an early end give no result.
//   Reset clears the decode state, empties the result register and skid
//   entry, and sets max_units to 256. When the receiver stalls, one more
//   result is caught in the skid entry and bytes then holds ready low
//   until the receiver takes a result.
`default_nettype none

module utf8_to_utf16_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          max_units_we,
	input  wire logic [u8u16_pkg::COUNT_W-1:0] max_units_wdata,
	u8u16_byte_if.sink                         bytes,
	u8u16_unit_if.source                       units
);
	import u8u16_pkg::*;

	logic  can_take, take, res_valid, out_valid;
	unit_t res, out_data;

	assign bytes.ready = can_take;
	assign take        = bytes.valid && can_take;

	u8u16_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (max_units_we),
		.cfg_wdata (max_units_wdata),
		.take      (take),
		.byte_in   (bytes.in_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	u8u16_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (units.ready),
		.out_data  (out_data)
	);

	assign units.valid      = out_valid;
	assign units.code_unit  = out_data.code_unit;
	assign units.string_end = out_data.string_end;
	assign units.unit_count = out_data.unit_count;

endmodule

`default_nettype wire

FILE: bench/tb_utf8_to_utf16_decoder.sv
// Testbench for utf8_to_utf16_decoder: sends byte strings on the byte channel and
// checks each code unit or end marker against a local decoder model.
// Depends on u8u16_pkg, u8u16_if and the utf8_to_utf16_decoder RTL.
module tb_utf8_to_utf16_decoder;
	import u8u16_pkg::*;

	logic clk;
	logic arst_n;
	logic max_units_we;
	logic [COUNT_W-1:0] max_units_wdata;

	u8u16_byte_if byte_ch ();
	u8u16_unit_if unit_ch ();

	utf8_to_utf16_decoder u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.max_units_we    (max_units_we),
		.max_units_wdata (max_units_wdata),
		.bytes           (byte_ch.sink),
		.units           (unit_ch.source)
	);

	// decoder model state
	logic [COUNT_W-1:0] unit_limit  = MAX_UNITS_RST;
	logic [UNIT_W-1:0]  partial     = '0;
	logic [1:0]         pend        = PEND_NONE;
	logic [COUNT_W-1:0] emitted     = '0;
	bit                 dropping    = 1'b0;

	unit_t expected_units[$];
	int    mismatches    = 0;
	int    sent_bytes    = 0;
	bit    send_pace     = 1'b1;
	bit    take_pace     = 1'b1;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic void clear_string_state();
		partial  = '0;
		pend     = PEND_NONE;
		emitted  = '0;
		dropping = 1'b0;
	endfunction

	function automatic bit count_unit(input logic [UNIT_W-1:0] u, output unit_t res);
		emitted        = emitted + 1'b1;
		res.code_unit  = u;
		res.string_end = 1'b0;
		res.unit_count = emitted;
		return 1'b1;
	endfunction

	// returns 1 when the byte produces a result, which is left in res
	function automatic bit decode_byte(input logic [7:0] b, output unit_t res);
		res = '0;
		if (b == 8'h00) begin
			if (dropping) begin
				clear_string_state();
				return 1'b0;
			end
			res.string_end = 1'b1;
			res.unit_count = emitted;
			clear_string_state();
			return 1'b1;
		end
		if (dropping)
			return 1'b0;
		// any nonzero byte mid-sequence is a continuation, top bits ignored
		if (pend != PEND_NONE) begin
			partial = {partial[UNIT_W-7:0], b[5:0] & CONT_DATA[5:0]};
			pend    = pend - 1'b1;
			if (pend == PEND_NONE)
				return count_unit(partial, res);
			return 1'b0;
		end
		if (emitted >= unit_limit) begin
			res.string_end = 1'b1;
			res.unit_count = emitted;
			partial        = '0;
			dropping       = 1'b1;
			return 1'b1;
		end
		if ((b & ASCII_MASK) == 8'h00)
			return count_unit({8'h00, b}, res);
		if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			partial = {8'h00, b & LEAD_DATA};
			pend    = PEND_ONE;
			return 1'b0;
		end
		if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			partial = {8'h00, b & LEAD_DATA};
			pend    = PEND_TWO;
			return 1'b0;
		end
		return count_unit(REPLACEMENT, res);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		unit_t res;
		gap = send_pace ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		sent_bytes++;
		if (decode_byte(b, res))
			expected_units.push_back(res);
	endtask

	// block is idle once every result is in and the pipeline has settled
	task automatic drain_units();
		byte_ch.valid <= 1'b0;
		while (expected_units.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_max_units(input logic [COUNT_W-1:0] v);
		drain_units();
		max_units_we    <= 1'b1;
		max_units_wdata <= v;
		@(posedge clk);
		unit_limit = v;
		max_units_we <= 1'b0;
	endtask

	task automatic send_random_string(input int max_chars);
		int n;
		bit ended;
		ended = 1'b0;
		n = $urandom_range(0, max_chars);
		for (int i = 0; i < n && !ended; i++) begin
			case ($urandom_range(0, 15))
				0, 1, 2, 3, 4, 5: send_byte(8'($urandom_range(1, 8'h7F)));
				6, 7, 8: begin
					send_byte(8'hC0 | 8'($urandom_range(0, 8'h1F)));
					send_byte(8'h80 | 8'($urandom_range(0, 8'h3F)));
				end
				9, 10, 11: begin
					send_byte(8'hE0 | 8'($urandom_range(0, 8'h0F)));
					send_byte(8'h80 | 8'($urandom_range(0, 8'h3F)));
					send_byte(8'h80 | 8'($urandom_range(0, 8'h3F)));
				end
				12: send_byte(8'h80 | 8'($urandom_range(0, 8'h3F)));
				13: send_byte(8'hF0 | 8'($urandom_range(0, 8'h0F)));
				14: send_byte(8'($urandom_range(1, 255)));
				default: begin
					// sequence cut short by the terminator
					if ($urandom_range(0, 1)) begin
						send_byte(8'hC0 | 8'($urandom_range(0, 8'h1F)));
					end else begin
						send_byte(8'hE0 | 8'($urandom_range(0, 8'h0F)));
						if ($urandom_range(0, 1))
							send_byte(8'h80 | 8'($urandom_range(0, 8'h3F)));
					end
					send_byte(8'h00);
					ended = 1'b1;
				end
			endcase
		end
		if (!ended)
			send_byte(8'h00);
	endtask

	task automatic test_basic_decode();
		send_pace = 1'b1;
		take_pace = 1'b1;
		send_byte(8'h41); send_byte(8'h7F); send_byte(8'h01); send_byte(8'h00);
		send_byte(8'hC3); send_byte(8'hA9);
		send_byte(8'hDF); send_byte(8'hBF);
		send_byte(8'hC2); send_byte(8'h41);
		send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
		send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
		send_byte(8'h80); send_byte(8'hF0); send_byte(8'hFF);
		send_byte(8'hE2); send_byte(8'h82); send_byte(8'h00);
		send_byte(8'h00);
	endtask

	task automatic test_unit_limit();
		set_max_units(10'd0);
		send_byte(8'h41); send_byte(8'h42); send_byte(8'h00);
		set_max_units(10'd1);
		send_byte(8'h41); send_byte(8'h42); send_byte(8'h43); send_byte(8'h00);
		// multi-byte unit finishing on the limit, then a lead byte past it
		set_max_units(10'd2);
		send_byte(8'h41); send_byte(8'hC3); send_byte(8'hA9);
		send_byte(8'hE2); send_byte(8'h82); send_byte(8'h00);
	endtask

	task automatic test_full_length_string();
		send_pace = 1'b0;
		take_pace = 1'b0;
		set_max_units(10'd1023);
		repeat (1023) send_byte(8'($urandom_range(1, 8'h7F)));
		send_byte(8'h5A);
		send_byte(8'h5B);
		send_byte(8'h00);
		send_pace = 1'b1;
		take_pace = 1'b1;
	endtask

	task automatic test_random_strings();
		logic [COUNT_W-1:0] v;
		while (sent_bytes < 2000) begin
			case ($urandom_range(0, 5))
				0: v = 10'd0;
				1: v = 10'd1;
				2: v = 10'd1023;
				3: v = 10'($urandom_range(2, 40));
				4: v = 10'($urandom_range(0, 1023));
				default: v = MAX_UNITS_RST;
			endcase
			set_max_units(v);
			repeat (8) begin
				send_pace = ($urandom_range(0, 3) != 0);
				take_pace = ($urandom_range(0, 3) != 0);
				send_random_string(40);
			end
		end
	endtask

	initial begin : unit_sink
		int stall;
		unit_t want;
		unit_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = take_pace ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				unit_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			unit_ch.ready <= 1'b1;
			do @(posedge clk); while (!unit_ch.valid);
			if (expected_units.size() == 0) begin
				$display("%0t: unexpected result: expected none, got unit %h end %b count %0d",
					$time, unit_ch.code_unit, unit_ch.string_end, unit_ch.unit_count);
				mismatches++;
			end else begin
				want = expected_units.pop_front();
				if (unit_ch.code_unit !== want.code_unit) begin
					$display("%0t: code_unit expected %h got %h",
						$time, want.code_unit, unit_ch.code_unit);
					mismatches++;
				end
				if (unit_ch.string_end !== want.string_end) begin
					$display("%0t: string_end expected %b got %b",
						$time, want.string_end, unit_ch.string_end);
					mismatches++;
				end
				if (unit_ch.unit_count !== want.unit_count) begin
					$display("%0t: unit_count expected %0d got %0d",
						$time, want.unit_count, unit_ch.unit_count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n          <= 1'b0;
		max_units_we    <= 1'b0;
		max_units_wdata <= '0;
		byte_ch.valid   <= 1'b0;
		byte_ch.in_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_decode();
		test_unit_limit();
		test_full_length_string();
		test_random_strings();
		drain_units();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_units.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
